// ===== src/sparse_block_run_segmenter_macros.svh =====
// ----------------------------------------------------------------------------
// sparse block run segmenter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPARSE_BLOCK_RUN_SEGMENTER_MACROS_SVH
`define SPARSE_BLOCK_RUN_SEGMENTER_MACROS_SVH

// same-cycle implication
`define SBRS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBRS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrs_pkg
// widths, register codes and helpers of the sparse block run segmenter
// ----------------------------------------------------------------------------
package sbrs_pkg;

  localparam int BEAT_BYTES   = 8;
  localparam int OFF_W        = 64;
  localparam int LEN_W        = 32;
  localparam int DATA_W       = 8 * BEAT_BYTES;
  localparam int POS_W        = LEN_W + 1;   // relative positions, may pass the end by a block
  localparam int SHIFT_W      = 5;
  localparam int SHIFT_MIN    = 3;
  localparam int SHIFT_MAX    = 20;
  localparam int MAX_SEGS     = 3;
  localparam int CNT_W        = 2;
  localparam int IN_TDATA_W   = OFF_W + LEN_W + DATA_W;
  localparam int OUT_TDATA_W  = OFF_W + LEN_W;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic             SPARSE_RESET = 1'b1;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);
  localparam logic [SHIFT_W-1:0] SHIFT_IDLE  = SHIFT_W'(SHIFT_MIN);

  typedef enum logic [0:0] {
    REG_SPARSE_ENABLE   = 1'b0,
    REG_BLOCK_SIZE_LOG2 = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             zero;
    logic             last;
  } seg_t;

  // block size exponent limited to the supported range
  function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    r = s;
    if (s < SHIFT_W'(SHIFT_MIN)) r = SHIFT_W'(SHIFT_MIN);
    if (s > SHIFT_W'(SHIFT_MAX)) r = SHIFT_W'(SHIFT_MAX);
    return r;
  endfunction

endpackage

// ===== src/sparse_block_run_segmenter.sv =====
// ----------------------------------------------------------------------------
// sparse_block_run_segmenter
// splits a read command into zero-fill and data-write runs per aligned block
// ----------------------------------------------------------------------------
// flow: an item is taken into the input register and worked on there once the
//   output buffer is free or it yields no segment; its segments then go to the buffer
// throughput: one item per cycle while the output buffer can take it; the buffer
//   sends one segment per cycle while out_tready is high, so a beat with segments waits for it to drain
// reset: synchronous active-low rst_n clears control state, empties both
//   stages and restores sparse_enable 1 and block_size_log2 12
module sparse_block_run_segmenter
  import sbrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // command_offset, command_length, data_word
  input  logic                   in_tuser,   // first_beat
  input  logic                   in_tlast,   // last_beat
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // seg_offset, seg_length
  output logic                   out_tuser,  // seg_zero
  output logic                   out_tlast,  // seg_last
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic               sparse_en_r;
  logic [SHIFT_W-1:0] bsl_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sparse_en_r <= SPARSE_RESET;
      bsl_r       <= SHIFT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPARSE_ENABLE:   sparse_en_r <= cfg_pwdata[0];
        REG_BLOCK_SIZE_LOG2: bsl_r       <= cfg_pwdata[SHIFT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPARSE_ENABLE:   cfg_prdata = CFG_DW'(sparse_en_r);
      REG_BLOCK_SIZE_LOG2: cfg_prdata = CFG_DW'(bsl_r);
    endcase
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic              beat_v_r;
  logic              beat_first_r;
  logic [OFF_W-1:0]  beat_off_r;
  logic [LEN_W-1:0]  beat_len_r;
  logic [DATA_W-1:0] beat_data_r;
  logic              fire;       // beat in the input register is worked on
  logic              in_acc;

  // last_beat is informational; the byte count decides where a command ends
  assign in_tready = !beat_v_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_v_r <= 1'b0;
    end else if (in_acc) begin
      beat_v_r <= 1'b1;
    end else if (fire) begin
      beat_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      beat_first_r <= in_tuser;
      beat_off_r   <= in_tdata[OFF_W-1:0];
      beat_len_r   <= in_tdata[OFF_W +: LEN_W];
      beat_data_r  <= in_tdata[OFF_W+LEN_W +: DATA_W];
    end
  end

  // --------------------------------------------------------------------------
  // command state, positions relative to the command offset
  // --------------------------------------------------------------------------
  logic               cmd_sparse_r;
  logic [SHIFT_W-1:0] cmd_shift_r;
  logic [OFF_W-1:0]   cmd_base_r;
  logic [POS_W-1:0]   cend_r;     // command end
  logic [POS_W-1:0]   pos_r;      // position of the next beat
  logic [POS_W-1:0]   nbs_r;      // end of the block being scanned
  logic [POS_W-1:0]   rs_r;       // start of the open run
  logic               riz_r;      // open run is a zero run
  logic               baz_r;      // block seen so far is all zero

  // values in force for this beat: a first beat starts a fresh command
  logic               e_sparse;
  logic [SHIFT_W-1:0] e_shift;
  logic [OFF_W-1:0]   e_base;
  logic [POS_W-1:0]   e_cend, e_pos, e_nbs, e_rs;
  logic               e_riz, e_baz;
  logic [POS_W-1:0]   e_size, e_mask, e_head;

  always_comb begin
    e_shift = beat_first_r ? clamp_shift(bsl_r) : cmd_shift_r;
    e_size  = POS_W'(1) << e_shift;
    e_mask  = e_size - POS_W'(1);
    // distance from the command offset up to the first aligned block
    e_head  = (e_size - (POS_W'(beat_off_r[SHIFT_MAX-1:0]) & e_mask)) & e_mask;
    if (beat_first_r) begin
      e_sparse = sparse_en_r;
      e_base   = beat_off_r;
      e_cend   = POS_W'(beat_len_r);
      e_pos    = '0;
      e_nbs    = e_head + e_size;
      e_rs     = '0;
      e_riz    = 1'b0;
      e_baz    = 1'b1;
    end else begin
      e_sparse = cmd_sparse_r;
      e_base   = cmd_base_r;
      e_cend   = cend_r;
      e_pos    = pos_r;
      e_nbs    = nbs_r;
      e_rs     = rs_r;
      e_riz    = riz_r;
      e_baz    = baz_r;
    end
  end

  // --------------------------------------------------------------------------
  // block scan over the bytes of the beat
  // --------------------------------------------------------------------------
  logic             busy, blk_fits, nxt_fits, comp, kind_chg, ends;
  logic             a_zero, b_zero, riz1, baz1;
  logic [POS_W-1:0] bs, rem, dn, rs1, nbs1, i_raw, i_pt, q;

  assign busy     = e_pos < e_cend;
  assign bs       = e_nbs - e_size;                 // start of the current block
  assign rem      = e_cend - e_pos;
  assign dn       = e_nbs - e_pos;
  assign blk_fits = e_nbs <= e_cend;
  assign nxt_fits = (e_nbs + e_size) <= e_cend;

  // at most one block can close inside a beat since blocks are at least a beat long
  always_comb begin
    a_zero = e_baz;
    b_zero = 1'b1;
    q      = '0;
    for (int k = 0; k < BEAT_BYTES; k++) begin
      q = e_pos + POS_W'(k);
      if (beat_data_r[8*k +: 8] != 8'd0) begin
        // byte in the block being scanned
        if (e_sparse && blk_fits && q < e_cend && q < e_nbs && q >= bs) a_zero = 1'b0;
        // byte in the block that follows inside this beat
        if (e_sparse && nxt_fits && q < e_cend && q >= e_nbs) b_zero = 1'b0;
      end
    end
  end

  assign comp     = busy && e_sparse && blk_fits && dn <= POS_W'(BEAT_BYTES);
  assign kind_chg = comp && (a_zero != e_riz);
  assign rs1      = kind_chg ? bs : e_rs;
  assign riz1     = kind_chg ? a_zero : e_riz;
  assign nbs1     = comp ? e_nbs + e_size : e_nbs;
  assign baz1     = comp ? b_zero : a_zero;
  assign ends     = busy && rem <= POS_W'(BEAT_BYTES);

  // tail starts after the last whole block, never past the command end
  assign i_raw = comp ? e_nbs : bs;
  assign i_pt  = (i_raw > e_cend) ? e_cend : i_raw;

  // --------------------------------------------------------------------------
  // segment candidates in model order: run closed by a kind change, then
  // the final run and the unaligned tail
  // --------------------------------------------------------------------------
  seg_t              cand   [0:MAX_SEGS-1];
  logic [MAX_SEGS-1:0] cand_v;
  seg_t              pack   [0:MAX_SEGS-1];
  logic [CNT_W-1:0]  nseg;

  always_comb begin
    cand[0] = '{offset: e_base + OFF_W'(e_rs), length: LEN_W'(bs - e_rs),
                zero: e_riz, last: 1'b0};
    cand_v[0] = kind_chg && (bs > e_rs);
    if (e_sparse) begin
      cand[1] = '{offset: e_base + OFF_W'(rs1), length: LEN_W'(i_pt - rs1),
                  zero: riz1, last: (i_pt == e_cend)};
      cand_v[1] = ends && (i_pt > rs1);
      cand[2] = '{offset: e_base + OFF_W'(i_pt), length: LEN_W'(e_cend - i_pt),
                  zero: 1'b0, last: 1'b1};
      cand_v[2] = ends && (e_cend > i_pt);
    end else begin
      // whole command as one write
      cand[1] = '{offset: e_base, length: LEN_W'(e_cend), zero: 1'b0, last: 1'b1};
      cand_v[1] = ends;
      cand[2] = cand[1];
      cand_v[2] = 1'b0;
    end
  end

  always_comb begin
    nseg = '0;
    for (int j = 0; j < MAX_SEGS; j++) pack[j] = cand[0];
    for (int j = 0; j < MAX_SEGS; j++) begin
      if (cand_v[j]) begin
        pack[nseg] = cand[j];
        nseg       = nseg + CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // output buffer, head entry drives the result channel
  // --------------------------------------------------------------------------
  seg_t             seg_r [0:MAX_SEGS-1];
  logic [CNT_W-1:0] cnt_r;
  logic             pop, buf_free;

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {seg_r[0].length, seg_r[0].offset};
  assign out_tuser  = seg_r[0].zero;
  assign out_tlast  = seg_r[0].last;

  assign pop      = out_tvalid && out_tready;
  assign buf_free = (cnt_r == '0) || (pop && cnt_r == CNT_W'(1));
  // a beat with no segment never waits on the result side
  assign fire     = beat_v_r && (buf_free || nseg == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fire && nseg != '0) begin
      cnt_r <= nseg;
    end else if (pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && nseg != '0) begin
      for (int j = 0; j < MAX_SEGS; j++) seg_r[j] <= pack[j];
    end else if (pop) begin
      for (int j = 0; j < MAX_SEGS - 1; j++) seg_r[j] <= seg_r[j+1];
    end
  end

  // --------------------------------------------------------------------------
  // command state update
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos_nxt;

  assign pos_nxt = busy ? e_pos + POS_W'(BEAT_BYTES) : e_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_sparse_r <= 1'b0;
      cmd_shift_r  <= SHIFT_IDLE;
      cmd_base_r   <= '0;
      cend_r       <= '0;
      pos_r        <= '0;
      nbs_r        <= '0;
      rs_r         <= '0;
      riz_r        <= 1'b0;
      baz_r        <= 1'b1;
    end else if (fire) begin
      cmd_sparse_r <= e_sparse;
      cmd_shift_r  <= e_shift;
      cmd_base_r   <= e_base;
      cend_r       <= e_cend;
      pos_r        <= pos_nxt;
      nbs_r        <= nbs1;
      rs_r         <= rs1;
      riz_r        <= riz1;
      baz_r        <= baz1;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "sparse_block_run_segmenter_macros.svh"

  `SBRS_ASSERT_IMP(a_last_at_tail, out_tvalid && out_tlast, cnt_r == CNT_W'(1), "final segment not last in buffer")
  `SBRS_ASSERT_IMP(a_len_nonzero, out_tvalid, seg_r[0].length != '0, "zero length segment")
  `SBRS_ASSERT_NXT(a_load_count, fire && nseg != '0, cnt_r == $past(nseg), "segment count lost on load")
  `SBRS_ASSERT_IMP(a_block_ahead, pos_r < cend_r && cmd_sparse_r, nbs_r > pos_r, "scan block behind stream")
  `SBRS_ASSERT_IMP(a_run_behind, pos_r < cend_r, rs_r <= pos_r, "open run starts ahead of stream")

endmodule
